>>> design/spi_slave_register_access_assert.svh
// ----------------------------------------------------------------------------
// SPI slave register access: assertion macros
// Shared property forms for the checker, clocked on clock and off in reset.
// ----------------------------------------------------------------------------
`ifndef SPI_SLAVE_REGISTER_ACCESS_ASSERT_SVH
`define SPI_SLAVE_REGISTER_ACCESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSRA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssra: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSRA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssra: next-cycle check failed");

`endif

>>> design/ssra_pkg.sv
// ----------------------------------------------------------------------------
// SPI slave register access: package
// Access phase type, request function codes and command byte constants.
// ----------------------------------------------------------------------------
package ssra_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CMD  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   localparam logic [2:0] FUNC_SEL_FALL    = 3'd0;
   localparam logic [2:0] FUNC_SEL_RISE    = 3'd1;
   localparam logic [2:0] FUNC_SPI_BYTE    = 3'd2;
   localparam logic [2:0] FUNC_LOCAL_WRITE = 3'd3;
   localparam logic [2:0] FUNC_LOCAL_READ  = 3'd4;

   localparam logic [7:0] CMD_READ_FLAG   = 8'h80;
   localparam logic [7:0] CMD_INDEX_MASK  = 8'h7F;
   localparam logic [7:0] REG_COUNT_RESET = 8'd128;

endpackage

>>> design/spi_slave_register_access.sv
// ----------------------------------------------------------------------------
// SPI slave register access
// Slave side of a byte-wide register file, driven one event beat at a time.
// ----------------------------------------------------------------------------
// Each request beat is one SPI or local event; each gives exactly one response
// beat. The register file is a memory of MAX_REGS rows of REG_BYTES bytes with
// byte write enables and two registered read ports. An event writes the memory
// at the edge it is accepted and enters the read-issue stage; the memory is read
// as it moves on to the response stage, which stalls on rsp_ready. The block
// sustains one request per cycle while the response side does not stall.
// After reset a clearing pass zeroes every memory row, with req_ready low;
// csr writes to reg_count are taken throughout.
module spi_slave_register_access
   import ssra_pkg::*;
#(
   parameter int REG_BYTES = 4,
   parameter int MAX_REGS  = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [6:0] req_local_index,
   input  logic [1:0] req_local_byte,
   input  logic [7:0] req_local_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic [7:0] rsp_local_rdata,
   output logic [1:0] rsp_phase,
   output logic       rsp_addr_error,
   output logic       rsp_write_done,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int CntW = (REG_BYTES > 1) ? $clog2(REG_BYTES) : 1;
   localparam int RowW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

   typedef logic [REG_BYTES-1:0][7:0] row_type;

   // Access state
   phase_type         phase_ff, phase_in;
   logic              is_write_ff, is_write_in;
   logic [6:0]        index_ff, index_in;
   logic [CntW-1:0]   count_ff, count_in;
   row_type           stage_ff;
   logic [7:0]        reg_count_ff;

   // Clearing pass
   logic              clear_ff;
   logic [RowW-1:0]   clear_row_ff;

   // Register memory
   row_type           reg_mem_ff [MAX_REGS];
   logic [REG_BYTES-1:0] wr_be;
   logic [RowW-1:0]   wr_row;
   row_type           wr_data;

   // Read-issue stage
   logic              s1_valid_ff;
   phase_type         s1_phase_ff;
   logic [RowW-1:0]   s1_trow_ff, s1_lrow_ff;
   logic [CntW-1:0]   s1_tpos_ff, s1_lpos_ff;
   logic              s1_lrd_ff, s1_err_ff, s1_done_ff;

   // Response stage
   logic              s2_valid_ff;
   phase_type         s2_phase_ff;
   logic [CntW-1:0]   s2_tpos_ff, s2_lpos_ff;
   logic              s2_lrd_ff, s2_err_ff, s2_done_ff;
   row_type           trow_data_ff, lrow_data_ff;

   logic req_acc, s1_adv;
   logic cmd_ok, last_byte, stage_we, commit, err, done;
   logic local_wr, local_rd;

   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !clear_ff && (!s1_valid_ff || s1_adv);
   assign req_acc   = req_valid && req_ready;

   assign cmd_ok = ({1'b0, req_rx_byte[6:0]} < reg_count_ff)
                   && (32'(req_rx_byte[6:0]) < MAX_REGS);
   assign last_byte = (32'(count_ff) >= REG_BYTES - 1);

   assign local_wr = req_acc && (req_func == FUNC_LOCAL_WRITE)
                     && (32'(req_local_byte) < REG_BYTES)
                     && (32'(req_local_index) < MAX_REGS);
   assign local_rd = (req_func == FUNC_LOCAL_READ)
                     && (32'(req_local_byte) < REG_BYTES)
                     && (32'(req_local_index) < MAX_REGS);

   // Access phase sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         is_write_ff <= 1'b0;
         index_ff    <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         is_write_ff <= is_write_in;
         index_ff    <= index_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      is_write_in = is_write_ff;
      index_in    = index_ff;
      count_in    = count_ff;
      stage_we    = 1'b0;
      commit      = 1'b0;
      err         = 1'b0;
      done        = 1'b0;
      if (req_acc) begin
         unique case (req_func)
            FUNC_SEL_FALL: begin
               phase_in = PH_CMD;
               count_in = '0;
            end
            FUNC_SEL_RISE: begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
            FUNC_SPI_BYTE: begin
               unique case (phase_ff)
                  PH_CMD: begin
                     is_write_in = ((req_rx_byte & CMD_READ_FLAG) == 8'h00);
                     index_in    = 7'(req_rx_byte & CMD_INDEX_MASK);
                     count_in    = '0;
                     if (cmd_ok) begin
                        phase_in = PH_DATA;
                     end else begin
                        err      = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_DATA: begin
                     stage_we = is_write_ff;
                     if (last_byte) begin
                        commit   = is_write_ff;
                        done     = is_write_ff;
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end else begin
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_ff[count_ff] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_count_ff <= REG_COUNT_RESET;
      end else if (csr_wr_en) begin
         reg_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
      end else if (clear_ff) begin
         if (clear_row_ff == RowW'(MAX_REGS - 1)) begin
            clear_ff <= 1'b0;
         end else begin
            clear_row_ff <= clear_row_ff + RowW'(1);
         end
      end
   end

   // Memory write port: clearing pass, write commit or a single local byte.
   // The commit takes the last data beat straight from the request.
   always_comb begin
      wr_be   = '0;
      wr_row  = '0;
      wr_data = '0;
      if (clear_ff) begin
         wr_be  = '1;
         wr_row = clear_row_ff;
      end else if (commit) begin
         wr_be             = '1;
         wr_row            = index_ff[RowW-1:0];
         wr_data           = stage_ff;
         wr_data[count_ff] = req_rx_byte;
      end else if (local_wr) begin
         for (int b = 0; b < REG_BYTES; b++) begin
            wr_be[b] = (32'(req_local_byte) == b);
         end
         wr_row  = req_local_index[RowW-1:0];
         wr_data = {REG_BYTES{req_local_data}};
      end
   end

   // Reads return the old contents, so an event accepted at the same edge
   // does not disturb the response of the one before it.
   always_ff @(posedge clock) begin
      for (int b = 0; b < REG_BYTES; b++) begin
         if (wr_be[b]) begin
            reg_mem_ff[wr_row][b] <= wr_data[b];
         end
      end
      if (s1_adv) begin
         trow_data_ff <= reg_mem_ff[s1_trow_ff];
         lrow_data_ff <= reg_mem_ff[s1_lrow_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_phase_ff <= phase_in;
         s1_trow_ff  <= (phase_in == PH_DATA) ? index_in[RowW-1:0] : '0;
         s1_tpos_ff  <= (phase_in == PH_DATA) ? count_in : '0;
         s1_lrd_ff   <= local_rd;
         s1_lrow_ff  <= req_local_index[RowW-1:0];
         s1_lpos_ff  <= CntW'(req_local_byte);
         s1_err_ff   <= err;
         s1_done_ff  <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_phase_ff <= s1_phase_ff;
         s2_tpos_ff  <= s1_tpos_ff;
         s2_lrd_ff   <= s1_lrd_ff;
         s2_lpos_ff  <= s1_lpos_ff;
         s2_err_ff   <= s1_err_ff;
         s2_done_ff  <= s1_done_ff;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_tx_byte     = (s2_phase_ff != PH_IDLE) ? trow_data_ff[s2_tpos_ff] : 8'h00;
   assign rsp_local_rdata = s2_lrd_ff ? lrow_data_ff[s2_lpos_ff] : 8'h00;
   assign rsp_phase       = s2_phase_ff;
   assign rsp_addr_error  = s2_err_ff;
   assign rsp_write_done  = s2_done_ff;

endmodule

>>> design/ssra_checker.sv
// ----------------------------------------------------------------------------
// SPI slave register access: port checker
// Checks response beats for consistency between phase, error and commit, and that a stalled beat holds.
// ----------------------------------------------------------------------------
`include "spi_slave_register_access_assert.svh"

module ssra_assertions
   import ssra_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic [1:0] rsp_phase,
   input logic       rsp_addr_error,
   input logic       rsp_write_done
);

   // Nothing is shifted out once the access has ended.
   `SSRA_ASSERT_SAME(a_idle_tx_zero, rsp_valid && (rsp_phase == PH_IDLE), rsp_tx_byte == 8'h00)

   // A rejected command ends the access and commits nothing.
   `SSRA_ASSERT_SAME(a_error_ends, rsp_valid && rsp_addr_error, (rsp_phase == PH_IDLE) && !rsp_write_done)

   // A commit happens only on the last data beat, which ends the access.
   `SSRA_ASSERT_SAME(a_commit_ends, rsp_valid && rsp_write_done, rsp_phase == PH_IDLE)

   `SSRA_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tx_byte))

endmodule

bind spi_slave_register_access ssra_assertions u_ssra_assertions (.*);

>>> test/ssra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave register access: response checker
// Watches the request, response and csr ports, keeps its own copy of the
// access state and the register file, and checks every response beat
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module ssra_checker
   import ssra_pkg::*;
#(
   parameter int REG_BYTES = 4,
   parameter int MAX_REGS  = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [6:0] req_local_index,
   input  logic [1:0] req_local_byte,
   input  logic [7:0] req_local_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_tx_byte,
   input  logic [7:0] rsp_local_rdata,
   input  logic [1:0] rsp_phase,
   input  logic       rsp_addr_error,
   input  logic       rsp_write_done,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         mismatch_count,
   output int         awaited_count
);

   typedef struct packed {
      logic [7:0] tx_byte;
      logic [7:0] local_rdata;
      phase_type  phase;
      logic       addr_error;
      logic       write_done;
   } access_result_type;

   phase_type         acc_phase;
   logic              acc_is_write;
   logic [6:0]        acc_index;
   logic [2:0]        acc_byte;
   logic [7:0]        reg_count_q;
   logic [7:0]        staged [REG_BYTES];
   logic [7:0]        reg_file [MAX_REGS][REG_BYTES];
   access_result_type awaited_results [$];

   // Advances the access state by one request beat and returns its response.
   task automatic spi_access_step(input logic [2:0] code, input logic [7:0] rx,
                                  input logic [6:0] idx, input logic [1:0] pos,
                                  input logic [7:0] data, output access_result_type res);
      int limit;
      res   = '0;
      limit = (reg_count_q < MAX_REGS) ? reg_count_q : MAX_REGS;
      case (code)
         FUNC_SEL_FALL: begin
            acc_phase = PH_CMD;
            acc_byte  = '0;
         end
         FUNC_SEL_RISE: begin
            acc_phase = PH_IDLE;
            acc_byte  = '0;
         end
         FUNC_SPI_BYTE: begin
            if (acc_phase == PH_CMD) begin
               acc_is_write = ((rx & CMD_READ_FLAG) == '0);
               acc_index    = 7'(rx & CMD_INDEX_MASK);
               acc_byte     = '0;
               if (acc_index < limit) begin
                  acc_phase = PH_DATA;
               end else begin
                  res.addr_error = 1'b1;
                  acc_phase      = PH_IDLE;
               end
            end else if (acc_phase == PH_DATA) begin
               if (acc_is_write && acc_byte < REG_BYTES) staged[acc_byte] = rx;
               if (int'(acc_byte) + 1 >= REG_BYTES) begin
                  // The whole register is committed at once after its last byte.
                  if (acc_is_write) begin
                     for (int i = 0; i < REG_BYTES; i++) reg_file[acc_index][i] = staged[i];
                     res.write_done = 1'b1;
                  end
                  acc_phase = PH_IDLE;
                  acc_byte  = '0;
               end else begin
                  acc_byte = acc_byte + 3'd1;
               end
            end
         end
         FUNC_LOCAL_WRITE: begin
            if (pos < REG_BYTES) reg_file[idx][pos] = data;
         end
         FUNC_LOCAL_READ: begin
            if (pos < REG_BYTES) res.local_rdata = reg_file[idx][pos];
         end
         default: ;
      endcase
      if (acc_phase == PH_CMD) res.tx_byte = reg_file[0][0];
      else if (acc_phase == PH_DATA) res.tx_byte = reg_file[acc_index][acc_byte];
      res.phase = acc_phase;
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      access_result_type res;
      if (reset) begin
         acc_phase    = PH_IDLE;
         acc_is_write = 1'b0;
         acc_index    = '0;
         acc_byte     = '0;
         reg_count_q  = REG_COUNT_RESET;
         for (int i = 0; i < REG_BYTES; i++) staged[i] = '0;
         for (int r = 0; r < MAX_REGS; r++)
            for (int i = 0; i < REG_BYTES; i++) reg_file[r][i] = '0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) reg_count_q = csr_wr_data;
         // A response beat always belongs to an earlier request, so it is
         // checked before this edge's request is predicted.
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               res = awaited_results.pop_front();
               check_field("tx_byte", res.tx_byte, rsp_tx_byte);
               check_field("local_rdata", res.local_rdata, rsp_local_rdata);
               check_field("phase", 8'(res.phase), 8'(rsp_phase));
               check_field("addr_error", 8'(res.addr_error), 8'(rsp_addr_error));
               check_field("write_done", 8'(res.write_done), 8'(rsp_write_done));
            end
         end
         if (req_valid && req_ready) begin
            spi_access_step(req_func, req_rx_byte, req_local_index, req_local_byte,
                            req_local_data, res);
            awaited_results.push_back(res);
         end
      end
      awaited_count = awaited_results.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI slave register access: testbench
// Drives directed and random SPI and local event beats with random idling on
// both channels, changes reg_count between phases, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
   import ssra_pkg::*;

   localparam int REG_BYTES       = 4;
   localparam int MAX_REGS        = 128;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 55;

   // Function codes with no operation behind them.
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [2:0] req_func        = FUNC_SEL_RISE;
   logic [7:0] req_rx_byte     = '0;
   logic [6:0] req_local_index = '0;
   logic [1:0] req_local_byte  = '0;
   logic [7:0] req_local_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic [7:0] rsp_local_rdata;
   logic [1:0] rsp_phase;
   logic       rsp_addr_error;
   logic       rsp_write_done;
   logic       csr_wr_en       = 1'b0;
   logic [7:0] csr_wr_data     = '0;

   int mismatch_count;
   int awaited_count;
   int items_sent  = 0;
   int cfg_now     = REG_COUNT_RESET;
   int idle_cycles = 0;
   int rsp_left    = 0;
   bit burst       = 1'b0;

   spi_slave_register_access #(
      .REG_BYTES(REG_BYTES),
      .MAX_REGS (MAX_REGS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .req_local_index(req_local_index),
      .req_local_byte (req_local_byte),
      .req_local_data (req_local_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_local_rdata(rsp_local_rdata),
      .rsp_phase      (rsp_phase),
      .rsp_addr_error (rsp_addr_error),
      .rsp_write_done (rsp_write_done),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   ssra_checker #(
      .REG_BYTES(REG_BYTES),
      .MAX_REGS (MAX_REGS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .req_local_index(req_local_index),
      .req_local_byte (req_local_byte),
      .req_local_data (req_local_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_local_rdata(rsp_local_rdata),
      .rsp_phase      (rsp_phase),
      .rsp_addr_error (rsp_addr_error),
      .rsp_write_done (rsp_write_done),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Response side: ready stretches of random length broken by stalls.
   always @(posedge clock) begin
      if (rsp_left > 0) begin
         rsp_left <= rsp_left - 1;
      end else if (rsp_ready && $urandom_range(0, 99) < 40) begin
         rsp_ready <= 1'b0;
         rsp_left  <= idle_gap() - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Called at a rising edge; returns at the edge on which the beat is taken.
   task automatic send_event(input logic [2:0] code, input logic [7:0] rx,
                             input logic [6:0] idx, input logic [1:0] pos,
                             input logic [7:0] data);
      int gap;
      gap = (burst || $urandom_range(0, 1)) ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= code;
      req_rx_byte     <= rx;
      req_local_index <= idx;
      req_local_byte  <= pos;
      req_local_data  <= data;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   // SPI events carry random local fields so that those bits toggle as well.
   task automatic send_spi(input logic [2:0] code, input logic [7:0] rx);
      send_event(code, rx, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg_count(input int value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 8'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_now      = value & 8'hFF;
   endtask

   task automatic local_access(input int near);
      int         r;
      logic [6:0] idx;
      r   = $urandom_range(0, 99);
      idx = (r < 40) ? 7'(near) : (r < 80) ? 7'($urandom_range(0, 7))
                                           : 7'($urandom_range(0, 127));
      if ($urandom_range(0, 1)) begin
         send_event(FUNC_LOCAL_WRITE, 8'($urandom_range(0, 255)), idx,
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
         send_event(FUNC_LOCAL_READ, 8'($urandom_range(0, 255)), idx,
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
   endtask

   // One access from select fall to select rise, sometimes cut short.
   task automatic spi_transaction();
      int         lim;
      int         idx;
      int         n_bytes;
      logic [7:0] cmd;
      lim   = (cfg_now < MAX_REGS) ? cfg_now : MAX_REGS;
      burst = ($urandom_range(0, 4) == 0);
      if (lim > 0 && $urandom_range(0, 99) < 85) begin
         idx = $urandom_range(0, 1) ? $urandom_range(0, ((lim < 8) ? lim : 8) - 1)
                                    : $urandom_range(0, lim - 1);
      end else begin
         idx = $urandom_range(0, 127);
      end
      cmd = ($urandom_range(0, 1) ? CMD_READ_FLAG : 8'h00) | (8'(idx) & CMD_INDEX_MASK);
      send_spi(FUNC_SEL_FALL, 8'($urandom_range(0, 255)));
      send_spi(FUNC_SPI_BYTE, cmd);
      // After a rejected command the block is idle, so at most a stray byte follows.
      if (idx >= lim) n_bytes = $urandom_range(0, 1);
      else if ($urandom_range(0, 99) < 85) n_bytes = REG_BYTES;
      else n_bytes = $urandom_range(0, REG_BYTES - 1);
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(0, 99) < 15) local_access(idx);
         send_spi(FUNC_SPI_BYTE, 8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 9))
         0:       send_spi(FUNC_SEL_FALL, 8'($urandom_range(0, 255)));
         1, 2:    ;
         default: send_spi(FUNC_SEL_RISE, 8'($urandom_range(0, 255)));
      endcase
      burst = 1'b0;
   endtask

   initial begin
      int plan [RANDOM_PHASES];
      int target;
      int r;
      plan = '{128, 0, 1, 255, 129, 64, 0, 127, 2, 128};
      plan[6] = $urandom_range(0, 255);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Local port at the extremes, unused codes, and events while idle.
      send_event(FUNC_LOCAL_READ, 8'h00, 7'd0, 2'd0, 8'h00);
      send_event(FUNC_LOCAL_WRITE, 8'hFF, 7'd127, 2'd3, 8'hFF);
      send_event(FUNC_LOCAL_WRITE, 8'h00, 7'd0, 2'd0, 8'hA5);
      send_event(FUNC_LOCAL_READ, 8'hFF, 7'd127, 2'd3, 8'hFF);
      send_event(FUNC_SPARE_LO, 8'h5A, 7'd64, 2'd2, 8'h5A);
      send_event(FUNC_SPARE_HI, 8'hFF, 7'd127, 2'd3, 8'hFF);
      send_spi(FUNC_SPI_BYTE, 8'h33);
      send_spi(FUNC_SEL_RISE, 8'h00);
      // Write to register 5 with a local write landing during the access.
      send_spi(FUNC_SEL_FALL, 8'h00);
      send_spi(FUNC_SPI_BYTE, 8'h05);
      send_spi(FUNC_SPI_BYTE, 8'h11);
      send_spi(FUNC_SPI_BYTE, 8'h22);
      send_event(FUNC_LOCAL_WRITE, 8'h00, 7'd5, 2'd2, 8'h77);
      send_spi(FUNC_SPI_BYTE, 8'h33);
      send_spi(FUNC_SPI_BYTE, 8'h44);
      send_spi(FUNC_SEL_RISE, 8'h00);
      // Read it back; received bytes are ignored during a read.
      send_spi(FUNC_SEL_FALL, 8'h00);
      send_spi(FUNC_SPI_BYTE, 8'h85);
      for (int i = 0; i < REG_BYTES; i++) send_spi(FUNC_SPI_BYTE, 8'hFF);
      // Highest index, restarted mid access and then aborted.
      send_spi(FUNC_SEL_FALL, 8'h00);
      send_spi(FUNC_SPI_BYTE, 8'h7F);
      send_spi(FUNC_SPI_BYTE, 8'hEE);
      send_spi(FUNC_SEL_FALL, 8'h00);
      send_spi(FUNC_SEL_RISE, 8'h00);

      // With no registers open to SPI every command is rejected.
      write_reg_count(0);
      send_spi(FUNC_SEL_FALL, 8'h00);
      send_spi(FUNC_SPI_BYTE, 8'h80);
      send_spi(FUNC_SEL_FALL, 8'h00);
      send_spi(FUNC_SPI_BYTE, 8'h00);

      foreach (plan[p]) begin
         write_reg_count(plan[p]);
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               spi_transaction();
            end else if (r < 85) begin
               local_access($urandom_range(0, 127));
            end else if (r < 96) begin
               send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
            end else begin
               drain_results();
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
